@@ hw/rtl/rosi_pkg.sv @@
// Shared widths, record types and saturation helper for the ray versus
// oriented-box slab intersection core. No dependencies.
`default_nettype none

package rosi_pkg;

  localparam int LANE_W   = 16;
  localparam int VEC_W    = 48;
  localparam int NAX      = 3;
  localparam int OFF_W    = 17;              // center minus origin
  localparam int EP_W     = 33;              // axis * offset
  localparam int PP_W     = 32;              // axis * direction
  localparam int E_W      = 35;              // offset projection
  localparam int P_W      = 34;              // direction projection
  localparam int N_W      = 36;              // slab numerator e +/- h
  localparam int NMAG_W   = 34;              // numerator magnitude
  localparam int FRAC_W   = 16;              // time fraction bits
  localparam int AX_FRAC  = 14;              // axis fraction bits
  localparam int DVD_W    = NMAG_W + FRAC_W; // dividend and quotient bits
  localparam int DIV_W    = 32;              // divisor magnitude
  localparam int T_W      = DVD_W + 1;       // signed slab time
  localparam int TIME_W   = 31;
  localparam int NDIV     = 2 * NAX;
  localparam int THR_W    = 16;
  localparam int SAT_IN_W = 34;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam int FRONT_STAGES = 4;
  localparam int BACK_STAGES  = 4;
  localparam int LATENCY  = FRONT_STAGES + DVD_W + BACK_STAGES;

  localparam logic [ADDR_W-3:0] REG_THRESHOLD = 1'b0;
  localparam logic [THR_W-1:0]  THR_RESET     = 16'd1;
  localparam logic [TIME_W-1:0] TIME_MAX      = {TIME_W{1'b1}};

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DVD_W-1:0] dvd;
    logic [DVD_W-1:0] quo;
    logic [DIV_W-1:0] dvs;
  } div_t;

  typedef struct packed {
    logic [VEC_W-1:0]          org;
    logic [VEC_W-1:0]          dir;
    logic [NAX-1:0][VEC_W-1:0] axes;
    logic [NAX-1:0]            near_pos;  // e + h > 0
    logic [NDIV-1:0]           q_neg;     // quotient sign
    logic [NAX-1:0]            par;       // axis treated as parallel
    logic                      pmiss;     // parallel axis outside slab
  } side_t;

  function automatic logic [LANE_W-1:0] sat16(input logic signed [SAT_IN_W-1:0] v);
    logic [LANE_W-1:0] r;
    if (v > 34'sd32767) r = 16'h7FFF;
    else if (v < -34'sd32768) r = 16'h8000;
    else r = v[LANE_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ray_obb_slab_intersect_core.sv @@
// Top level of the ray versus oriented-box slab intersection core: APB
// register, front end, divider cell chain and result stages. Depends on
// rosi_pkg, rosi_front and rosi_div_cell.
`default_nettype none

// Streaming ray/OBB test. Assert start with one ray and one box; busy is
// always low, so a new item may be issued in every clock cycle. Each item
// passes through 4 front stages (offsets, projection multipliers, sums, slab
// numerators), a chain of 50 division cells that each resolve one quotient bit
// of all six slab times, and 4 back stages (ordering, interval fold, contact
// multipliers, output register) on its way from start to its done strobe.
// Results appear in issue order on hit, entry_time, contact_normal
// and contact_point for exactly one cycle while done is high; there is no way
// to stall them, so capture every done cycle. On a miss all result fields
// read zero. The parallel_threshold register (APB byte address 0, reset 1)
// may only be written while no item is in flight.
module ray_obb_slab_intersect_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // command channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [rosi_pkg::VEC_W-1:0]    ray_origin,
  input  wire logic [rosi_pkg::VEC_W-1:0]    ray_direction,
  input  wire logic [rosi_pkg::VEC_W-1:0]    box_center,
  input  wire logic [rosi_pkg::VEC_W-1:0]    box_axis_zero,
  input  wire logic [rosi_pkg::VEC_W-1:0]    box_axis_one,
  input  wire logic [rosi_pkg::VEC_W-1:0]    box_axis_two,
  input  wire logic [rosi_pkg::VEC_W-1:0]    box_half_sizes,
  // result channel
  output logic                               done,
  output logic                               hit,
  output logic [rosi_pkg::TIME_W-1:0]        entry_time,
  output logic [rosi_pkg::VEC_W-1:0]         contact_normal,
  output logic [rosi_pkg::VEC_W-1:0]         contact_point,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rosi_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [rosi_pkg::DATA_W-1:0]   pwdata,
  output logic [rosi_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int LW  = rosi_pkg::LANE_W;
  localparam int NA  = rosi_pkg::NAX;
  localparam int NC  = rosi_pkg::DVD_W;
  localparam int LAT = rosi_pkg::LATENCY;

  // ---------------------------------------------------------------- register
  logic [rosi_pkg::THR_W-1:0] threshold;
  logic                       wr_xfer;

  assign pready  = 1'b1;
  assign wr_xfer = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= rosi_pkg::THR_RESET;
    end else if (wr_xfer && (paddr[rosi_pkg::ADDR_W-1:2] == rosi_pkg::REG_THRESHOLD)) begin
      threshold <= pwdata[rosi_pkg::THR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[rosi_pkg::ADDR_W-1:2] == rosi_pkg::REG_THRESHOLD) begin
      prdata = {{(rosi_pkg::DATA_W-rosi_pkg::THR_W){1'b0}}, threshold};
    end
  end

  // Fully pipelined: never hold off a command.
  assign busy = 1'b0;

  // --------------------------------------------------------------- front end
  logic                                ch_v    [NC+1];
  rosi_pkg::div_t [rosi_pkg::NDIV-1:0] ch_div  [NC+1];
  rosi_pkg::side_t                     ch_side [NC+1];

  rosi_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (start && !busy),
    .ray_origin     (ray_origin),
    .ray_direction  (ray_direction),
    .box_center     (box_center),
    .box_axis_zero  (box_axis_zero),
    .box_axis_one   (box_axis_one),
    .box_axis_two   (box_axis_two),
    .box_half_sizes (box_half_sizes),
    .threshold      (threshold),
    .out_valid      (ch_v[0]),
    .out_div        (ch_div[0]),
    .out_side       (ch_side[0])
  );

  // ------------------------------------------------------ divider cell chain
  // Cell i resolves quotient bit NC-1-i of every slab time and hands the
  // partial remainder to cell i+1.
  for (genvar i = 0; i < NC; i++) begin : g_cell
    rosi_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (ch_v[i]),
      .in_div    (ch_div[i]),
      .in_side   (ch_side[i]),
      .out_valid (ch_v[i+1]),
      .out_div   (ch_div[i+1]),
      .out_side  (ch_side[i+1])
    );
  end

  // ---------------------------------------------- back stage 1: signed order
  logic                               b1_v;
  rosi_pkg::side_t                    b1_side;
  logic signed [rosi_pkg::T_W-1:0]    b1_lo [NA];
  logic signed [rosi_pkg::T_W-1:0]    b1_hi [NA];
  logic signed [rosi_pkg::T_W-1:0]    t_c   [rosi_pkg::NDIV];

  always_comb begin
    for (int j = 0; j < rosi_pkg::NDIV; j++) begin
      t_c[j] = ch_side[NC].q_neg[j] ? -$signed({1'b0, ch_div[NC][j].quo})
                                    :  $signed({1'b0, ch_div[NC][j].quo});
    end
  end

  always_ff @(posedge clk) begin
    b1_side <= ch_side[NC];
    for (int a = 0; a < NA; a++) begin
      // swap so the slab interval runs low to high
      if (t_c[2*a] > t_c[2*a+1]) begin
        b1_lo[a] <= t_c[2*a+1];
        b1_hi[a] <= t_c[2*a];
      end else begin
        b1_lo[a] <= t_c[2*a];
        b1_hi[a] <= t_c[2*a+1];
      end
    end
  end

  // ------------------------------------------- back stage 2: interval fold
  // Start only rises and end only falls, so one check after all three axes
  // gives the same miss verdict as checking after each.
  logic                               b2_v, b2_hit;
  logic [rosi_pkg::TIME_W-1:0]        b2_time;
  logic [rosi_pkg::VEC_W-1:0]         b2_nrm, b2_org, b2_dir;
  logic signed [rosi_pkg::T_W-1:0]    st_c, en_c;
  logic [rosi_pkg::VEC_W-1:0]         nrm_c;
  logic                               miss_c;

  always_comb begin
    logic signed [rosi_pkg::SAT_IN_W-1:0] ax_x;
    ax_x  = '0;
    st_c  = '0;
    en_c  = {1'b0, {(rosi_pkg::T_W-1){1'b1}}};
    nrm_c = '0;
    for (int a = 0; a < NA; a++) begin
      if (!b1_side.par[a]) begin
        if (b1_lo[a] > st_c) begin
          st_c = b1_lo[a];
          for (int k = 0; k < NA; k++) begin
            ax_x = rosi_pkg::SAT_IN_W'($signed(b1_side.axes[a][LW*k +: LW]));
            nrm_c[LW*k +: LW] = b1_side.near_pos[a] ? rosi_pkg::sat16(-ax_x)
                                                    : b1_side.axes[a][LW*k +: LW];
          end
        end
        if (b1_hi[a] < en_c) en_c = b1_hi[a];
      end
    end
    miss_c = b1_side.pmiss || (st_c > en_c) || en_c[rosi_pkg::T_W-1];
  end

  always_ff @(posedge clk) begin
    b2_hit <= !miss_c;
    b2_time <= (st_c > $signed({{(rosi_pkg::T_W-rosi_pkg::TIME_W){1'b0}}, rosi_pkg::TIME_MAX}))
             ? rosi_pkg::TIME_MAX : st_c[rosi_pkg::TIME_W-1:0];
    b2_nrm <= nrm_c;
    b2_org <= b1_side.org;
    b2_dir <= b1_side.dir;
  end

  // ---------------------------------------- back stage 3: direction * time
  logic                               b3_v, b3_hit;
  logic [rosi_pkg::TIME_W-1:0]        b3_time;
  logic [rosi_pkg::VEC_W-1:0]         b3_nrm, b3_org;
  logic signed [LW+rosi_pkg::TIME_W:0] b3_prod [NA];

  always_ff @(posedge clk) begin
    b3_hit  <= b2_hit;
    b3_time <= b2_time;
    b3_nrm  <= b2_nrm;
    b3_org  <= b2_org;
    for (int k = 0; k < NA; k++) begin
      b3_prod[k] <= $signed(b2_dir[LW*k +: LW]) * $signed({1'b0, b2_time});
    end
  end

  // ----------------------------------------- back stage 4: contact, output
  logic [rosi_pkg::VEC_W-1:0] pt_c;

  always_comb begin
    logic signed [LW+rosi_pkg::TIME_W:0]   sh;
    logic signed [rosi_pkg::SAT_IN_W-1:0]  sum;
    for (int k = 0; k < NA; k++) begin
      sh  = b3_prod[k] >>> rosi_pkg::FRAC_W;   // floor toward minus infinity
      sum = rosi_pkg::SAT_IN_W'($signed(b3_org[LW*k +: LW])) + rosi_pkg::SAT_IN_W'(sh);
      pt_c[LW*k +: LW] = rosi_pkg::sat16(sum);
    end
  end

  always_ff @(posedge clk) begin
    hit            <= b3_hit;
    entry_time     <= b3_hit ? b3_time : '0;
    contact_normal <= b3_hit ? b3_nrm  : '0;
    contact_point  <= b3_hit ? pt_c    : '0;
  end

  // valid line through the back stages
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
      done <= 1'b0;
    end else begin
      b1_v <= ch_v[NC];
      b2_v <= b1_v;
      b3_v <= b2_v;
      done <= b3_v;
    end
  end

`ifndef SYNTHESIS
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("command transfer did not produce a result at the fixed latency");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> (entry_time == '0) && (contact_normal == '0) && (contact_point == '0))
    else $error("miss result carries nonzero fields");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/rosi_div_cell.sv @@
// One restoring-division cell: one quotient bit for all six slab divisions,
// with the item's side data riding along. Depends on rosi_pkg.
`default_nettype none

module rosi_div_cell (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire rosi_pkg::div_t [rosi_pkg::NDIV-1:0] in_div,
  input  wire rosi_pkg::side_t                     in_side,
  output logic                                     out_valid,
  output rosi_pkg::div_t [rosi_pkg::NDIV-1:0]      out_div,
  output rosi_pkg::side_t                          out_side
);

  logic [rosi_pkg::NDIV-1:0][rosi_pkg::DIV_W:0] r2;
  logic [rosi_pkg::NDIV-1:0][rosi_pkg::DIV_W:0] diff;
  logic [rosi_pkg::NDIV-1:0]                    ge;
  rosi_pkg::div_t [rosi_pkg::NDIV-1:0]          div_next;

  always_comb begin
    for (int j = 0; j < rosi_pkg::NDIV; j++) begin
      r2[j]   = {in_div[j].rem, in_div[j].dvd[rosi_pkg::DVD_W-1]};
      diff[j] = r2[j] - {1'b0, in_div[j].dvs};
      ge[j]   = (r2[j] >= {1'b0, in_div[j].dvs});
      div_next[j].rem = ge[j] ? diff[j][rosi_pkg::DIV_W-1:0] : r2[j][rosi_pkg::DIV_W-1:0];
      div_next[j].dvd = {in_div[j].dvd[rosi_pkg::DVD_W-2:0], 1'b0};
      div_next[j].quo = {in_div[j].quo[rosi_pkg::DVD_W-2:0], ge[j]};
      div_next[j].dvs = in_div[j].dvs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_div  <= div_next;
    out_side <= in_side;
  end

endmodule

`default_nettype wire

@@ hw/rtl/rosi_front.sv @@
// Front end: offsets, axis projections, slab numerators and parallel test,
// four register stages feeding the divider chain. Depends on rosi_pkg.
`default_nettype none

module rosi_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic [rosi_pkg::VEC_W-1:0]          ray_origin,
  input  wire logic [rosi_pkg::VEC_W-1:0]          ray_direction,
  input  wire logic [rosi_pkg::VEC_W-1:0]          box_center,
  input  wire logic [rosi_pkg::VEC_W-1:0]          box_axis_zero,
  input  wire logic [rosi_pkg::VEC_W-1:0]          box_axis_one,
  input  wire logic [rosi_pkg::VEC_W-1:0]          box_axis_two,
  input  wire logic [rosi_pkg::VEC_W-1:0]          box_half_sizes,
  input  wire logic [rosi_pkg::THR_W-1:0]          threshold,
  output logic                                     out_valid,
  output rosi_pkg::div_t [rosi_pkg::NDIV-1:0]      out_div,
  output rosi_pkg::side_t                          out_side
);

  localparam int LW = rosi_pkg::LANE_W;
  localparam int NA = rosi_pkg::NAX;

  // stage 1: offsets
  logic [NA-1:0][rosi_pkg::OFF_W-1:0] off_c;
  logic                               v1;
  logic [rosi_pkg::VEC_W-1:0]         org1, dir1, half1;
  logic [NA-1:0][rosi_pkg::VEC_W-1:0] ax1;
  logic [rosi_pkg::OFF_W-1:0]         off1 [NA];

  // stage 2: products
  logic                               v2;
  logic [rosi_pkg::VEC_W-1:0]         org2, dir2, half2;
  logic [NA-1:0][rosi_pkg::VEC_W-1:0] ax2;
  logic signed [rosi_pkg::EP_W-1:0]   ep2 [NA][NA];
  logic signed [rosi_pkg::PP_W-1:0]   pp2 [NA][NA];

  // stage 3: projections
  logic                               v3;
  logic [rosi_pkg::VEC_W-1:0]         org3, dir3, half3;
  logic [NA-1:0][rosi_pkg::VEC_W-1:0] ax3;
  logic signed [rosi_pkg::E_W-1:0]    e3 [NA];
  logic signed [rosi_pkg::P_W-1:0]    p3 [NA];

  // stage 4 combinational
  rosi_pkg::div_t [rosi_pkg::NDIV-1:0] div_next;
  rosi_pkg::side_t                     side_next;

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      off_c[k] = {box_center[LW*k+LW-1], box_center[LW*k +: LW]}
               - {ray_origin[LW*k+LW-1], ray_origin[LW*k +: LW]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    org1  <= ray_origin;
    dir1  <= ray_direction;
    half1 <= box_half_sizes;
    ax1   <= {box_axis_two, box_axis_one, box_axis_zero};
    for (int k = 0; k < NA; k++) off1[k] <= off_c[k];

    org2 <= org1;
    dir2 <= dir1;
    half2 <= half1;
    ax2 <= ax1;
    for (int a = 0; a < NA; a++) begin
      for (int k = 0; k < NA; k++) begin
        ep2[a][k] <= $signed(ax1[a][LW*k +: LW]) * $signed(off1[k]);
        pp2[a][k] <= $signed(ax1[a][LW*k +: LW]) * $signed(dir1[LW*k +: LW]);
      end
    end

    org3 <= org2;
    dir3 <= dir2;
    half3 <= half2;
    ax3 <= ax2;
    for (int a = 0; a < NA; a++) begin
      e3[a] <= rosi_pkg::E_W'(ep2[a][0]) + rosi_pkg::E_W'(ep2[a][1])
             + rosi_pkg::E_W'(ep2[a][2]);
      p3[a] <= rosi_pkg::P_W'(pp2[a][0]) + rosi_pkg::P_W'(pp2[a][1])
             + rosi_pkg::P_W'(pp2[a][2]);
    end

    out_div  <= div_next;
    out_side <= side_next;
  end

  // Numerators, magnitudes and the parallel test for each axis.
  always_comb begin
    logic signed [rosi_pkg::N_W-1:0] e_x, h_x, n1, n2, n1a, n2a;
    logic signed [rosi_pkg::P_W-1:0] pa;
    logic [rosi_pkg::DIV_W-1:0]      pmag;
    logic                            par;
    side_next = '0;
    div_next  = '0;
    side_next.org  = org3;
    side_next.dir  = dir3;
    side_next.axes = ax3;
    for (int a = 0; a < NA; a++) begin
      e_x  = rosi_pkg::N_W'(e3[a]);
      h_x  = $signed({6'b0, half3[LW*a +: LW], {rosi_pkg::AX_FRAC{1'b0}}});
      n1   = e_x + h_x;
      n2   = e_x - h_x;
      n1a  = n1[rosi_pkg::N_W-1] ? -n1 : n1;
      n2a  = n2[rosi_pkg::N_W-1] ? -n2 : n2;
      pa   = p3[a][rosi_pkg::P_W-1] ? -p3[a] : p3[a];
      pmag = pa[rosi_pkg::DIV_W-1:0];
      par  = (p3[a] == '0) || (pmag < {2'b0, threshold, {rosi_pkg::AX_FRAC{1'b0}}});

      side_next.par[a]      = par;
      side_next.near_pos[a] = (n1 > 0);
      // outside the slab: e + h below zero or e - h above zero
      if (par && (n1[rosi_pkg::N_W-1] || (n2 > 0))) side_next.pmiss = 1'b1;
      side_next.q_neg[2*a]   = n1[rosi_pkg::N_W-1] ^ p3[a][rosi_pkg::P_W-1];
      side_next.q_neg[2*a+1] = n2[rosi_pkg::N_W-1] ^ p3[a][rosi_pkg::P_W-1];

      div_next[2*a].dvd   = {n1a[rosi_pkg::NMAG_W-1:0], {rosi_pkg::FRAC_W{1'b0}}};
      div_next[2*a].dvs   = pmag;
      div_next[2*a+1].dvd = {n2a[rosi_pkg::NMAG_W-1:0], {rosi_pkg::FRAC_W{1'b0}}};
      div_next[2*a+1].dvs = pmag;
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_ray_obb_slab_intersect_core.sv @@
// Self-checking bench for ray_obb_slab_intersect_core: directed and random ray/box
// tests predicted in the bench and compared result by result.
// Depends on rosi_pkg and the core RTL.
`default_nettype none

module tb_ray_obb_slab_intersect_core;

  localparam int VEC_W   = rosi_pkg::VEC_W;
  localparam int TIME_W  = rosi_pkg::TIME_W;
  localparam int THR_W   = rosi_pkg::THR_W;
  localparam int ADDR_W  = rosi_pkg::ADDR_W;
  localparam int DATA_W  = rosi_pkg::DATA_W;
  localparam int LATENCY = rosi_pkg::LATENCY;

  typedef struct packed {
    logic              hit;
    logic [TIME_W-1:0] t;
    logic [VEC_W-1:0]  nrm;
    logic [VEC_W-1:0]  pt;
  } isect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [VEC_W-1:0] ray_origin = '0, ray_direction = '0, box_center = '0;
  logic [VEC_W-1:0] box_axis_zero = '0, box_axis_one = '0, box_axis_two = '0;
  logic [VEC_W-1:0] box_half_sizes = '0;
  logic done, hit;
  logic [TIME_W-1:0] entry_time;
  logic [VEC_W-1:0] contact_normal, contact_point;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  ray_obb_slab_intersect_core dut (.*);

  always #6 clk = ~clk;

  // Bench copy of the threshold register, and the results still owed.
  logic [THR_W-1:0] thr_shadow = rosi_pkg::THR_RESET;
  isect_t pending_isects[$];
  int errors = 0;
  bit quiet = 1'b0;   // no random gaps in the closing stretch

  function automatic longint lane(logic [VEC_W-1:0] v, int k);
    return longint'($signed(v[16*k +: 16]));
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Slab test of one ray against one oriented box.
  function automatic isect_t predict_isect(logic [VEC_W-1:0] o, logic [VEC_W-1:0] d,
      logic [VEC_W-1:0] c, logic [VEC_W-1:0] a0, logic [VEC_W-1:0] a1,
      logic [VEC_W-1:0] a2, logic [VEC_W-1:0] hs);
    isect_t r;
    longint off[3], nrm[3], ax[3];
    longint t0, t1, tlo, thi, e, p, h, ap, q, thr, fl;
    logic [VEC_W-1:0] axv;
    t0 = 0;
    t1 = 64'sh7FFF_FFFF_FFFF_FFFF;
    thr = longint'(thr_shadow) * 16384;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      off[k] = lane(c, k) - lane(o, k);
      nrm[k] = 0;
    end
    for (int a = 0; a < 3; a++) begin
      axv = (a == 0) ? a0 : (a == 1) ? a1 : a2;
      e = 0;
      p = 0;
      for (int k = 0; k < 3; k++) begin
        ax[k] = lane(axv, k);
        e += ax[k] * off[k];
        p += ax[k] * lane(d, k);
      end
      h = longint'(hs[16*a +: 16]) * 16384;
      ap = (p < 0) ? -p : p;
      if (p == 0 || ap < thr) begin
        if (e < -h || e > h) return '0;
      end else begin
        tlo = ((e + h) * 65536) / p;
        thi = ((e - h) * 65536) / p;
        if (tlo > thi) begin
          q = tlo;
          tlo = thi;
          thi = q;
        end
        if (tlo > t0) begin
          t0 = tlo;
          for (int k = 0; k < 3; k++) nrm[k] = (e + h > 0) ? clamp16(-ax[k]) : ax[k];
        end
        if (thi < t1) t1 = thi;
        if (t0 > t1 || t1 < 0) return '0;
      end
    end
    if (t0 > 64'sh7FFF_FFFF) t0 = 64'sh7FFF_FFFF;
    r.hit = 1'b1;
    r.t = t0[TIME_W-1:0];
    for (int k = 0; k < 3; k++) begin
      q = lane(d, k) * t0;
      fl = (q >= 0) ? q / 65536 : -((-q + 65535) / 65536);
      fl = clamp16(lane(o, k) + fl);
      r.nrm[16*k +: 16] = nrm[k][15:0];
      r.pt[16*k +: 16] = fl[15:0];
    end
    return r;
  endfunction

  // Compare every done strobe against the oldest owed result.
  always @(posedge clk) begin
    isect_t exp_r;
    if (!rst && done) begin
      if (pending_isects.size() == 0) begin
        $error("result with nothing outstanding");
        errors++;
      end else begin
        exp_r = pending_isects.pop_front();
        if (hit !== exp_r.hit) begin
          $error("hit exp %0h got %0h", exp_r.hit, hit); errors++;
        end
        if (entry_time !== exp_r.t) begin
          $error("entry_time exp %0h got %0h", exp_r.t, entry_time); errors++;
        end
        if (contact_normal !== exp_r.nrm) begin
          $error("contact_normal exp %0h got %0h", exp_r.nrm, contact_normal); errors++;
        end
        if (contact_point !== exp_r.pt) begin
          $error("contact_point exp %0h got %0h", exp_r.pt, contact_point); errors++;
        end
      end
    end
  end

  // Issue one ray/box item; hold start until the transfer completes.
  task automatic send_ray(logic [VEC_W-1:0] o, logic [VEC_W-1:0] d, logic [VEC_W-1:0] c,
      logic [VEC_W-1:0] a0, logic [VEC_W-1:0] a1, logic [VEC_W-1:0] a2,
      logic [VEC_W-1:0] hs);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    ray_origin <= o; ray_direction <= d; box_center <= c;
    box_axis_zero <= a0; box_axis_one <= a1; box_axis_two <= a2;
    box_half_sizes <= hs;
    do @(posedge clk); while (busy);
    pending_isects = {pending_isects, predict_isect(o, d, c, a0, a1, a2, hs)};
  endtask

  // Drain the pipeline, then write the threshold with an APB setup and access phase.
  task automatic write_threshold(logic [THR_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (pending_isects.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {rosi_pkg::REG_THRESHOLD, 2'b00}; pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    thr_shadow = v;
    @(posedge clk);
  endtask

  function automatic logic [VEC_W-1:0] pack_vec(int x, int y, int z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  // Raw random bits for one packed vector.
  function automatic logic [VEC_W-1:0] rand_vec();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[VEC_W-1:0];
  endfunction

  localparam int ONE_AX = 16384;

  // Lane-aligned unit axis i with a random sign, or a pair rotated about z.
  function automatic logic [VEC_W-1:0] rand_axis(int i, int rot);
    int s;
    s = ($urandom_range(0, 1) ? -ONE_AX : ONE_AX);
    if (rot == 0)
      return (i == 0) ? pack_vec(s, 0, 0) : (i == 1) ? pack_vec(0, s, 0) : pack_vec(0, 0, s);
    // 45 degree rotation about z: 11585 ~ 16384/sqrt2
    return (i == 0) ? pack_vec(11585, 11585, 0) :
           (i == 1) ? pack_vec(-11585, 11585, 0) : pack_vec(0, 0, s);
  endfunction

  function automatic int rand_small(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  task automatic test_directed();
    logic [VEC_W-1:0] ax0, ax1, ax2, cube;
    ax0 = pack_vec(ONE_AX, 0, 0);
    ax1 = pack_vec(0, ONE_AX, 0);
    ax2 = pack_vec(0, 0, ONE_AX);
    cube = pack_vec(256, 256, 256);
    // head-on hit along +x, and from the far side
    send_ray(pack_vec(-1280, 0, 0), pack_vec(256, 0, 0), '0, ax0, ax1, ax2, cube);
    send_ray(pack_vec(1280, 0, 0), pack_vec(-256, 0, 0), '0, ax0, ax1, ax2, cube);
    // origin inside: no raising axis
    send_ray('0, pack_vec(256, 128, 0), '0, ax0, ax1, ax2, cube);
    // parallel axes, inside and outside the slab
    send_ray(pack_vec(-1280, 0, 0), pack_vec(256, 0, 0), '0, ax0, ax1, ax2, cube);
    send_ray(pack_vec(-1280, 1024, 0), pack_vec(256, 0, 0), '0, ax0, ax1, ax2, cube);
    // box behind the ray
    send_ray(pack_vec(1280, 0, 0), pack_vec(256, 0, 0), '0, ax0, ax1, ax2, cube);
    // zero direction
    send_ray('0, '0, '0, ax0, ax1, ax2, cube);
    send_ray(pack_vec(2000, 0, 0), '0, '0, ax0, ax1, ax2, cube);
    // saturated time and contact point: tiny direction, far box
    send_ray(pack_vec(-32768, 0, 0), pack_vec(1, 0, 0), pack_vec(32767, 0, 0),
             ax0, ax1, ax2, pack_vec(16, 32767, 32767));
    // extremes of every field
    send_ray({VEC_W{1'b1}}, {VEC_W{1'b1}}, {VEC_W{1'b1}}, {VEC_W{1'b1}},
             {VEC_W{1'b1}}, {VEC_W{1'b1}}, {VEC_W{1'b1}});
    send_ray({3{16'h8000}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h8000}},
             {3{16'h8000}}, {3{16'h8000}}, {VEC_W{1'b1}});
    send_ray({3{16'h7FFF}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h7FFF}},
             {3{16'h8000}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    // negative axis -32768 saturates when negated
    send_ray(pack_vec(-1280, 0, 0), pack_vec(256, 0, 0), '0,
             pack_vec(-32768, 0, 0), ax1, ax2, pack_vec(512, 256, 256));
    // rotated box
    send_ray(pack_vec(-1280, 100, 0), pack_vec(256, 0, 0), '0,
             pack_vec(11585, 11585, 0), pack_vec(-11585, 11585, 0), ax2, cube);
    send_ray('0, '0, '0, '0, '0, '0, '0);
  endtask

  task automatic test_random(int n);
    logic [VEC_W-1:0] o, d, c, a0, a1, a2, hs;
    int rot, sel;
    for (int i = 0; i < n; i++) begin
      sel = int'($urandom_range(0, 9));
      if (sel < 8) begin
        // well-formed geometry at modest scale
        rot = ($urandom_range(0, 2) == 0) ? 1 : 0;
        c = pack_vec(rand_small(1024), rand_small(1024), rand_small(1024));
        o = pack_vec(rand_small(4096), rand_small(4096), rand_small(4096));
        d = (sel == 0) ? pack_vec(rand_small(512), 0, 0)
                       : pack_vec(rand_small(512), rand_small(512), rand_small(512));
        a0 = rand_axis(0, rot); a1 = rand_axis(1, rot); a2 = rand_axis(2, rot);
        hs = pack_vec(rand_small(512) + 512, rand_small(512) + 512,
                      rand_small(512) + 512);
      end else begin
        // raw bits
        o = rand_vec(); d = rand_vec(); c = rand_vec();
        a0 = rand_vec(); a1 = rand_vec();
        a2 = rand_vec(); hs = rand_vec();
      end
      send_ray(o, d, c, a0, a1, a2, hs);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(200);
    write_threshold(16'd0);
    test_directed();
    test_random(150);
    write_threshold(16'hFFFF);
    test_random(100);
    write_threshold(16'd300);
    test_random(200);
    write_threshold(rosi_pkg::THR_RESET);
    quiet = 1'b1;
    test_random(200);
    start <= 1'b0;
    while (pending_isects.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/rosi_pkg.sv
hw/rtl/rosi_div_cell.sv
hw/rtl/rosi_front.sv
hw/rtl/ray_obb_slab_intersect_core.sv
bench/tb_ray_obb_slab_intersect_core.sv
